@@ rtl/mau_pkg.sv @@
// ----------------------------------------------------------------------------
// mau_pkg
// Shared types and constants of the modular arithmetic unit: field widths,
// command codes and the default word size.
// ----------------------------------------------------------------------------
`default_nettype none

package mau_pkg;

  // Fixed widths of the request and result fields
  localparam int CMD_BITS  = 3;
  localparam int DATA_BITS = 32;

  // Default operand width inside the unit
  localparam int WORD_BITS_DEF = 32;

  typedef logic [CMD_BITS-1:0]  cmd_t;
  typedef logic [DATA_BITS-1:0] data_t;

  // Command codes
  localparam cmd_t CMD_DIV = 3'd0;
  localparam cmd_t CMD_RED = 3'd1;
  localparam cmd_t CMD_ADD = 3'd2;
  localparam cmd_t CMD_SUB = 3'd3;
  localparam cmd_t CMD_MUL = 3'd4;
  localparam cmd_t CMD_EXP = 3'd5;

endpackage : mau_pkg

`default_nettype wire

@@ rtl/mau_in_if.sv @@
// ----------------------------------------------------------------------------
// mau_in_if
// Request channel of the modular arithmetic unit: valid/ready handshake with
// the command and its three operands.
// ----------------------------------------------------------------------------
`default_nettype none

interface mau_in_if
  import mau_pkg::*;
();

  logic  valid;
  logic  ready;
  cmd_t  command;
  data_t operand_a;
  data_t operand_b;
  data_t modulus;

  modport source (output valid, output command, output operand_a, output operand_b,
                  output modulus, input ready);
  modport sink   (input valid, input command, input operand_a, input operand_b,
                  input modulus, output ready);

endinterface : mau_in_if

`default_nettype wire

@@ rtl/mau_out_if.sv @@
// ----------------------------------------------------------------------------
// mau_out_if
// Result channel of the modular arithmetic unit: valid/ready handshake with
// the result, the remainder and the zero divisor flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface mau_out_if
  import mau_pkg::*;
();

  logic  valid;
  logic  ready;
  data_t result;
  data_t remainder;
  logic  zero_divisor;

  modport source (output valid, output result, output remainder, output zero_divisor,
                  input ready);
  modport sink   (input valid, input result, input remainder, input zero_divisor,
                  output ready);

endinterface : mau_out_if

`default_nettype wire

@@ rtl/modular_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// modular_arithmetic_unit
// Divide, reduce, modular add/subtract/multiply and modular exponentiation
// on WORD_BITS-bit operands, built around one bit-serial reducer and one
// word multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// One request is worked on at a time; in_ch.ready is high only while the
// sequencer is idle. Operands and modulus are cut to their low WORD_BITS bits
// and results are zero extended to 32 bits. All division work goes through a
// restoring shift-subtract reducer that retires one bit per cycle over a
// 2*WORD_BITS-bit dividend. Divide and reduce run one reduction, add and
// subtract two, multiply three (both operands, then the product), and each
// request also passes through the idle state that takes it, the dispatch
// state and the state that loads the output register. Exponentiation
// reduces the base, then takes one exponent bit at a time, with a modular
// multiply (product, then its reduction) for each square and each multiply:
// one square per exponent bit plus one more multiply per set bit. A zero
// divisor or needed zero modulus skips the work and returns zero with
// zero_divisor set. The finished result sits in an output register, so a new
// request is taken while the previous result waits for out_ch.ready.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_arithmetic_unit
  import mau_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mau_in_if.sink     in_ch,
  mau_out_if.source  out_ch
);

  localparam int W   = WORD_BITS;
  localparam int CW  = $clog2(2 * W);
  localparam int SW  = 3;

  // Sequencer states
  localparam logic [SW-1:0] S_IDLE = 3'd0;
  localparam logic [SW-1:0] S_DISP = 3'd1;
  localparam logic [SW-1:0] S_RA   = 3'd2;
  localparam logic [SW-1:0] S_RB   = 3'd3;
  localparam logic [SW-1:0] S_MUL  = 3'd4;
  localparam logic [SW-1:0] S_RP   = 3'd5;
  localparam logic [SW-1:0] S_EXP  = 3'd6;
  localparam logic [SW-1:0] S_FIN  = 3'd7;

  logic [SW-1:0]  state_r, state_nxt;
  cmd_t           cmd_r, cmd_nxt;
  logic [W-1:0]   a_r, a_nxt;
  logic [W-1:0]   b_r, b_nxt;
  logic [W-1:0]   n_r, n_nxt;
  logic [W-1:0]   opx_r, opx_nxt;     // x, or accumulator in exponentiation
  logic [W-1:0]   opy_r, opy_nxt;     // y, or base in exponentiation
  logic [W-1:0]   e_r, e_nxt;         // remaining exponent bits
  logic           sq_r, sq_nxt;       // current product is the squaring
  logic [2*W-1:0] dd_r, dd_nxt;       // dividend in, quotient out
  logic [W-1:0]   div_r, div_nxt;
  logic [W-1:0]   rem_r, rem_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [W-1:0]   res_r, res_nxt;
  logic [W-1:0]   remo_r, remo_nxt;
  logic           err_r, err_nxt;

  logic           out_valid_r, out_valid_nxt;
  logic [W-1:0]   out_res_r, out_res_nxt;
  logic [W-1:0]   out_rem_r, out_rem_nxt;
  logic           out_err_r, out_err_nxt;

  // Shared reducer step: shift in one dividend bit, subtract if it fits
  logic [W:0]     trial;
  logic [W:0]     trial_diff;
  logic           trial_ge;
  logic [W-1:0]   rem_step;
  logic [2*W-1:0] dd_step;

  assign trial      = {rem_r, dd_r[2*W-1]};
  assign trial_diff = trial - {1'b0, div_r};
  assign trial_ge   = (trial >= {1'b0, div_r});
  assign rem_step   = trial_ge ? trial_diff[W-1:0] : trial[W-1:0];
  assign dd_step    = {dd_r[2*W-2:0], trial_ge};

  // Shared multiplier
  logic [W-1:0]   mul_x;
  logic [W-1:0]   mul_y;
  logic [2*W-1:0] mul_p;

  assign mul_x = sq_r ? opy_r : opx_r;
  assign mul_y = opy_r;
  assign mul_p = mul_x * mul_y;

  // Final add/subtract with one conditional correction
  logic [W:0] addend;
  logic [W:0] sum_raw;
  logic [W:0] sum_cor;
  logic [W-1:0] sum_mod;

  assign addend  = (cmd_r == CMD_SUB) ? ({1'b0, n_r} - {1'b0, rem_step})
                                      : {1'b0, rem_step};
  assign sum_raw = {1'b0, opx_r} + addend;
  assign sum_cor = sum_raw - {1'b0, n_r};
  assign sum_mod = (sum_raw >= {1'b0, n_r}) ? sum_cor[W-1:0] : sum_raw[W-1:0];

  logic n_zero;
  assign n_zero = (n_r == '0);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    n_nxt         = n_r;
    opx_nxt       = opx_r;
    opy_nxt       = opy_r;
    e_nxt         = e_r;
    sq_nxt        = sq_r;
    dd_nxt        = dd_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    remo_nxt      = remo_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    out_rem_nxt   = out_rem_r;
    out_err_nxt   = out_err_r;

    // result taken downstream
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt   = in_ch.command;
          a_nxt     = in_ch.operand_a[W-1:0];
          b_nxt     = in_ch.operand_b[W-1:0];
          n_nxt     = in_ch.modulus[W-1:0];
          state_nxt = S_DISP;
        end
      end

      // special cases, else start reducing the first operand
      S_DISP: begin
        res_nxt   = '0;
        remo_nxt  = '0;
        err_nxt   = 1'b0;
        sq_nxt    = 1'b0;
        dd_nxt    = {{W{1'b0}}, a_r};
        div_nxt   = n_r;
        rem_nxt   = '0;
        cnt_nxt   = CW'(2 * W - 1);
        state_nxt = S_RA;
        case (cmd_r)
          CMD_DIV: begin
            div_nxt = b_r;
            if (b_r == '0) begin
              err_nxt   = 1'b1;
              state_nxt = S_FIN;
            end
          end
          CMD_RED: begin
            if (a_r == '0) begin
              state_nxt = S_FIN;
            end else if (n_zero) begin
              err_nxt   = 1'b1;
              state_nxt = S_FIN;
            end
          end
          CMD_ADD, CMD_SUB, CMD_MUL: begin
            if (n_zero) begin
              err_nxt   = (a_r != '0) || (b_r != '0);
              state_nxt = S_FIN;
            end
          end
          CMD_EXP: begin
            if (b_r == '0) begin
              res_nxt   = W'(1);
              state_nxt = S_FIN;
            end else if (n_zero) begin
              err_nxt   = !((b_r == W'(1)) && (a_r == '0));
              state_nxt = S_FIN;
            end
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end

      // reduce first operand
      S_RA: begin
        rem_nxt = rem_step;
        dd_nxt  = dd_step;
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          case (cmd_r)
            CMD_DIV: begin
              res_nxt   = dd_step[W-1:0];
              remo_nxt  = rem_step;
              state_nxt = S_FIN;
            end
            CMD_RED: begin
              res_nxt   = rem_step;
              state_nxt = S_FIN;
            end
            CMD_EXP: begin
              opy_nxt   = rem_step;
              opx_nxt   = (n_r == W'(1)) ? '0 : W'(1);
              e_nxt     = b_r;
              state_nxt = S_EXP;
            end
            default: begin
              // add, subtract, multiply: reduce the second operand next
              opx_nxt   = rem_step;
              dd_nxt    = {{W{1'b0}}, b_r};
              rem_nxt   = '0;
              cnt_nxt   = CW'(2 * W - 1);
              state_nxt = S_RB;
            end
          endcase
        end
      end

      // reduce second operand
      S_RB: begin
        rem_nxt = rem_step;
        dd_nxt  = dd_step;
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          opy_nxt = rem_step;
          if (cmd_r == CMD_MUL) begin
            state_nxt = S_MUL;
          end else begin
            res_nxt   = sum_mod;
            state_nxt = S_FIN;
          end
        end
      end

      // load the double-width product into the reducer, then reduce it
      S_MUL: begin
        state_nxt = S_RP;
      end

      S_RP: begin
        rem_nxt = rem_step;
        dd_nxt  = dd_step;
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          if (cmd_r == CMD_MUL) begin
            res_nxt   = rem_step;
            state_nxt = S_FIN;
          end else if (!sq_r) begin
            // accumulator updated, square the base next
            opx_nxt   = rem_step;
            sq_nxt    = 1'b1;
            state_nxt = S_MUL;
          end else begin
            opy_nxt   = rem_step;
            e_nxt     = {1'b0, e_r[W-1:1]};
            state_nxt = S_EXP;
          end
        end
      end

      // one exponent bit: multiply when set, then square
      S_EXP: begin
        if (e_r == '0) begin
          res_nxt   = opx_r;
          state_nxt = S_FIN;
        end else begin
          sq_nxt    = !e_r[0];
          state_nxt = S_MUL;
        end
      end

      // hand the result to the output register
      S_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          out_rem_nxt   = remo_r;
          out_err_nxt   = err_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // product reduction starts from the fresh product
    if (state_r == S_MUL) begin
      dd_nxt  = mul_p;
      div_nxt = n_r;
      rem_nxt = '0;
      cnt_nxt = CW'(2 * W - 1);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    n_r       <= n_nxt;
    opx_r     <= opx_nxt;
    opy_r     <= opy_nxt;
    e_r       <= e_nxt;
    sq_r      <= sq_nxt;
    dd_r      <= dd_nxt;
    div_r     <= div_nxt;
    rem_r     <= rem_nxt;
    cnt_r     <= cnt_nxt;
    res_r     <= res_nxt;
    remo_r    <= remo_nxt;
    err_r     <= err_nxt;
    out_res_r <= out_res_nxt;
    out_rem_r <= out_rem_nxt;
    out_err_r <= out_err_nxt;
  end

  // Channel outputs
  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.result       = DATA_BITS'(out_res_r);
  assign out_ch.remainder    = DATA_BITS'(out_rem_r);
  assign out_ch.zero_divisor = out_err_r;

endmodule : modular_arithmetic_unit

`default_nettype wire
